### design/dbs_pkg.sv
// ----------------------------------------------------------------------------
// dbs_pkg
// Shared types and constants for the debounced button status register.
// ----------------------------------------------------------------------------
package dbs_pkg;

  localparam logic [2:0] CMD_TICK        = 3'd0;
  localparam logic [2:0] CMD_STATUS      = 3'd1;
  localparam logic [2:0] CMD_CLEAR_COUNT = 3'd2;
  localparam logic [2:0] CMD_SET_COLOUR  = 3'd3;
  localparam logic [2:0] CMD_COLOUR_OFF  = 3'd4;

  localparam logic [7:0] DEBOUNCE_RESET = 8'd20;
  localparam logic [7:0] COUNT_MAX      = 8'd255;

  localparam int unsigned PADDR_W = 3;
  localparam logic [PADDR_W-1:0] ADDR_DEBOUNCE = 3'h0;

  typedef struct packed {
    logic [2:0] cmd;
    logic       raw_level;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] white_in;
  } dbs_item_t;

  typedef struct packed {
    logic       pressed_now;
    logic       press_seen;
    logic       release_seen;
    logic [7:0] press_total;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] white_out;
    logic       colour_changed;
  } dbs_result_t;

endpackage

### design/dbs_in_if.sv
// ----------------------------------------------------------------------------
// dbs_in_if
// Item channel into the block: command, raw pin level and colour channels.
// ----------------------------------------------------------------------------
interface dbs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic       raw_level;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] white_in;

  modport source (output valid, cmd, raw_level, red_in, green_in, blue_in, white_in,
                  input ready);
  modport sink   (input valid, cmd, raw_level, red_in, green_in, blue_in, white_in,
                  output ready);
endinterface

### design/dbs_out_if.sv
// ----------------------------------------------------------------------------
// dbs_out_if
// Result channel out of the block: button status and stored colour.
// ----------------------------------------------------------------------------
interface dbs_out_if;
  logic       valid;
  logic       ready;
  logic       pressed_now;
  logic       press_seen;
  logic       release_seen;
  logic [7:0] press_total;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] white_out;
  logic       colour_changed;

  modport source (output valid, pressed_now, press_seen, release_seen, press_total,
                         red_out, green_out, blue_out, white_out, colour_changed,
                  input ready);
  modport sink   (input valid, pressed_now, press_seen, release_seen, press_total,
                        red_out, green_out, blue_out, white_out, colour_changed,
                  output ready);
endinterface

### design/dbs_cfg.sv
// ----------------------------------------------------------------------------
// dbs_cfg
// APB register slave holding the debounce length.
// ----------------------------------------------------------------------------
module dbs_cfg
  import dbs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [7:0]         debounce_ticks_o
);

  logic [7:0] debounce_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == ADDR_DEBOUNCE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
    end else if (wr_en) begin
      debounce_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_DEBOUNCE) begin
      prdata = {24'd0, debounce_q};
    end
  end

  assign debounce_ticks_o = debounce_q;

endmodule

### design/dbs_core.sv
// ----------------------------------------------------------------------------
// dbs_core
// Debounce state, edge flags, press counter and colour store; works out the
// result of one item and commits the new state when the item advances.
// ----------------------------------------------------------------------------
module dbs_core
  import dbs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  dbs_item_t   item_i,
  input  logic [7:0]  debounce_ticks_i,
  output dbs_result_t result_o
);

  logic        stable_q, stable_d;
  logic [7:0]  mismatch_q, mismatch_d;
  logic        pressed_q, pressed_d;
  logic        press_flag_q, press_flag_d;
  logic        release_flag_q, release_flag_d;
  logic [7:0]  counter_q, counter_d;
  logic [31:0] colour_q, colour_d;
  logic [7:0]  mismatch_inc;
  logic        seen_press, seen_release, changed;

  assign mismatch_inc = (mismatch_q == COUNT_MAX) ? COUNT_MAX : mismatch_q + 8'd1;

  always_comb begin
    stable_d       = stable_q;
    mismatch_d     = mismatch_q;
    pressed_d      = pressed_q;
    press_flag_d   = press_flag_q;
    release_flag_d = release_flag_q;
    counter_d      = counter_q;
    colour_d       = colour_q;
    changed        = 1'b0;

    case (item_i.cmd)
      CMD_TICK: begin
        if (item_i.raw_level == stable_q) begin
          mismatch_d = '0;
        end else if (mismatch_inc >= debounce_ticks_i) begin
          // level held long enough: take it as the new stable level
          stable_d   = item_i.raw_level;
          mismatch_d = '0;
          if (!item_i.raw_level) begin
            pressed_d    = 1'b1;
            press_flag_d = 1'b1;
            if (counter_q != COUNT_MAX) begin
              counter_d = counter_q + 8'd1;
            end
          end else begin
            pressed_d      = 1'b0;
            release_flag_d = 1'b1;
          end
        end else begin
          mismatch_d = mismatch_inc;
        end
      end
      CMD_CLEAR_COUNT: counter_d = '0;
      CMD_SET_COLOUR: begin
        colour_d = {item_i.white_in, item_i.blue_in, item_i.green_in, item_i.red_in};
        changed  = 1'b1;
      end
      CMD_COLOUR_OFF: begin
        colour_d = '0;
        changed  = 1'b1;
      end
      default: ;
    endcase

    // report the flags, then drop them on a status read
    seen_press   = press_flag_d;
    seen_release = release_flag_d;
    if (item_i.cmd == CMD_STATUS) begin
      press_flag_d   = 1'b0;
      release_flag_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q       <= 1'b1;
      mismatch_q     <= '0;
      pressed_q      <= 1'b0;
      press_flag_q   <= 1'b0;
      release_flag_q <= 1'b0;
      counter_q      <= '0;
      colour_q       <= '0;
    end else if (step_i) begin
      stable_q       <= stable_d;
      mismatch_q     <= mismatch_d;
      pressed_q      <= pressed_d;
      press_flag_q   <= press_flag_d;
      release_flag_q <= release_flag_d;
      counter_q      <= counter_d;
      colour_q       <= colour_d;
    end
  end

  always_comb begin
    result_o.pressed_now    = pressed_d;
    result_o.press_seen     = seen_press;
    result_o.release_seen   = seen_release;
    result_o.press_total    = counter_d;
    result_o.red_out        = colour_d[7:0];
    result_o.green_out      = colour_d[15:8];
    result_o.blue_out       = colour_d[23:16];
    result_o.white_out      = colour_d[31:24];
    result_o.colour_changed = changed;
  end

endmodule

### design/debounced_button_status_register.sv
// ----------------------------------------------------------------------------
// debounced_button_status_register
// Debounced button front end with edge flags, press counter and colour store.
// ----------------------------------------------------------------------------
// Every item gives exactly one result. An accepted item sits in an input
// register while the core works out its result and state update. The result
// register loads from the core when the item advances, and the result is offered on
// the output channel from there; one item per cycle is sustained while results are taken.
// The input register empties into the result register whenever that register is empty
// or being taken, so the input side stalls only while a result is held back.
// The debounce length is written over APB at byte address 0 (bits 7:0) and
// should be changed only while no item is in flight.
// ----------------------------------------------------------------------------
module debounced_button_status_register
  import dbs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  dbs_in_if.sink             in_i,
  dbs_out_if.source          out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic        s1_valid_q, s1_valid_d;
  dbs_item_t   s1_item_q;
  logic        out_valid_q, out_valid_d;
  dbs_result_t out_data_q;
  dbs_result_t result_d;
  logic        in_fire, advance;
  logic [7:0]  debounce_ticks;

  dbs_cfg u_cfg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .debounce_ticks_o (debounce_ticks)
  );

  dbs_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (advance),
    .item_i           (s1_item_q),
    .debounce_ticks_i (debounce_ticks),
    .result_o         (result_d)
  );

  assign advance  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_fire  = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q.cmd       <= in_i.cmd;
      s1_item_q.raw_level <= in_i.raw_level;
      s1_item_q.red_in    <= in_i.red_in;
      s1_item_q.green_in  <= in_i.green_in;
      s1_item_q.blue_in   <= in_i.blue_in;
      s1_item_q.white_in  <= in_i.white_in;
    end
    if (advance) begin
      out_data_q <= result_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.pressed_now    = out_data_q.pressed_now;
  assign out_o.press_seen     = out_data_q.press_seen;
  assign out_o.release_seen   = out_data_q.release_seen;
  assign out_o.press_total    = out_data_q.press_total;
  assign out_o.red_out        = out_data_q.red_out;
  assign out_o.green_out      = out_data_q.green_out;
  assign out_o.blue_out       = out_data_q.blue_out;
  assign out_o.white_out      = out_data_q.white_out;
  assign out_o.colour_changed = out_data_q.colour_changed;

  // an empty result register must never hold back the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty result register");

  // a held item stays in the input register until it moves on
  a_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> s1_valid_q)
    else $error("pending item dropped");

  // colour off clears all four channels and flags the change
  a_colour_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_item_q.cmd == CMD_COLOUR_OFF) |=>
      (out_valid_q && out_data_q.colour_changed && out_data_q.red_out == 8'd0 &&
       out_data_q.green_out == 8'd0 && out_data_q.blue_out == 8'd0 &&
       out_data_q.white_out == 8'd0))
    else $error("colour off result wrong");

endmodule

### tb/debounced_button_status_register_test.sv
// ----------------------------------------------------------------------------
// debounced_button_status_register_test
// Self-checking bench for the debounced button front end and colour store.
// A clocked driver feeds command transactions from a queue and a clocked
// monitor compares every result against a cycle-free model of the debounce,
// edge-flag, counter and colour behaviour. The debounce length is reprogrammed
// over APB between phases, and both channels are throttled at random.
// ----------------------------------------------------------------------------
module debounced_button_status_register_test;
  import dbs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0]  CMD_UNUSED_LAST  = 3'd7;
  localparam int unsigned CYCLE_LIMIT      = 600000;
  localparam int unsigned HOLDOFF_CYCLES   = 300;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  dbs_in_if  in_if ();
  dbs_out_if out_if ();

  debounced_button_status_register dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk_i = ~clk_i;

  // Model state
  logic [7:0]  debounce_setting;
  logic        stable_level;
  logic [7:0]  mismatch_run;
  logic        button_down;
  logic        press_edge;
  logic        release_edge;
  logic [7:0]  press_count;
  logic [7:0]  colour_r, colour_g, colour_b, colour_w;

  dbs_item_t   pending_items[$];
  dbs_result_t expected_results[$];

  bit          tx_idle_en;
  bit          rx_idle_en;
  int unsigned tx_gap_left;
  int unsigned rx_wait_left;
  int unsigned rx_holdoff_left;
  int unsigned holdoff_requests;
  int unsigned holdoff_served;
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned items_accepted;
  int unsigned results_checked;
  int unsigned settings_written;
  int unsigned presses_accepted;
  int unsigned saturated_presses;
  logic        gen_level;

  function automatic logic rnd_bit();
    return 1'($urandom);
  endfunction

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom);
  endfunction

  function automatic dbs_result_t button_predict(dbs_item_t it);
    dbs_result_t res;
    res = '0;
    case (it.cmd)
      CMD_TICK: begin
        if (it.raw_level == stable_level) begin
          mismatch_run = '0;
        end else begin
          if (mismatch_run < COUNT_MAX) mismatch_run = mismatch_run + 8'd1;
          // a zero setting accepts the first differing tick
          if (mismatch_run >= debounce_setting) begin
            stable_level = it.raw_level;
            mismatch_run = '0;
            if (!it.raw_level) begin
              button_down = 1'b1;
              press_edge  = 1'b1;
              presses_accepted++;
              if (press_count < COUNT_MAX) press_count = press_count + 8'd1;
              else saturated_presses++;
            end else begin
              button_down  = 1'b0;
              release_edge = 1'b1;
            end
          end
        end
      end
      CMD_CLEAR_COUNT: press_count = '0;
      CMD_SET_COLOUR: begin
        colour_r = it.red_in;
        colour_g = it.green_in;
        colour_b = it.blue_in;
        colour_w = it.white_in;
        res.colour_changed = 1'b1;
      end
      CMD_COLOUR_OFF: begin
        {colour_r, colour_g, colour_b, colour_w} = '0;
        res.colour_changed = 1'b1;
      end
      default: ;
    endcase
    res.press_seen   = press_edge;
    res.release_seen = release_edge;
    if (it.cmd == CMD_STATUS) begin
      press_edge   = 1'b0;
      release_edge = 1'b0;
    end
    res.pressed_now = button_down;
    res.press_total = press_count;
    res.red_out     = colour_r;
    res.green_out   = colour_g;
    res.blue_out    = colour_b;
    res.white_out   = colour_w;
    return res;
  endfunction

  task automatic compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  // Driver: hold the offered transaction until taken, then advance
  always @(posedge clk_i) begin
    dbs_item_t taken;
    dbs_item_t nxt;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        taken = '{cmd: in_if.cmd, raw_level: in_if.raw_level, red_in: in_if.red_in,
                  green_in: in_if.green_in, blue_in: in_if.blue_in,
                  white_in: in_if.white_in};
        expected_results.push_back(button_predict(taken));
        items_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (tx_gap_left > 0) begin
          tx_gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          nxt = pending_items.pop_front();
          in_if.cmd       <= nxt.cmd;
          in_if.raw_level <= nxt.raw_level;
          in_if.red_in    <= nxt.red_in;
          in_if.green_in  <= nxt.green_in;
          in_if.blue_in   <= nxt.blue_in;
          in_if.white_in  <= nxt.white_in;
          in_if.valid     <= 1'b1;
          tx_gap_left = tx_idle_en ? $urandom_range(0, 14) : 0;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction against the oldest expectation
  always @(posedge clk_i) begin
    dbs_result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: result expected none, got %0h", $time,
                   {out_if.pressed_now, out_if.press_seen, out_if.release_seen,
                    out_if.press_total, out_if.red_out, out_if.green_out,
                    out_if.blue_out, out_if.white_out, out_if.colour_changed});
        end else begin
          want = expected_results.pop_front();
          compare_field("pressed_now", 32'(want.pressed_now), 32'(out_if.pressed_now));
          compare_field("press_seen", 32'(want.press_seen), 32'(out_if.press_seen));
          compare_field("release_seen", 32'(want.release_seen),
                        32'(out_if.release_seen));
          compare_field("press_total", 32'(want.press_total), 32'(out_if.press_total));
          compare_field("red_out", 32'(want.red_out), 32'(out_if.red_out));
          compare_field("green_out", 32'(want.green_out), 32'(out_if.green_out));
          compare_field("blue_out", 32'(want.blue_out), 32'(out_if.blue_out));
          compare_field("white_out", 32'(want.white_out), 32'(out_if.white_out));
          compare_field("colour_changed", 32'(want.colour_changed),
                        32'(out_if.colour_changed));
          results_checked++;
        end
        rx_wait_left = rx_idle_en ? $urandom_range(0, 14) : 0;
      end
      if (holdoff_served != holdoff_requests) begin
        holdoff_served++;
        rx_holdoff_left = HOLDOFF_CYCLES;
      end
      if (rx_holdoff_left > 0) begin
        rx_holdoff_left--;
        out_if.ready <= 1'b0;
      end else if (rx_wait_left > 0) begin
        rx_wait_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("debounced_button_status_register_test: done, errors");
      $finish;
    end
  end

  task automatic queue_item(logic [2:0] cmd, logic lvl, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b, logic [7:0] w);
    pending_items.push_back('{cmd: cmd, raw_level: lvl, red_in: r, green_in: g,
                              blue_in: b, white_in: w});
  endtask

  task automatic queue_tick(logic lvl);
    queue_item(CMD_TICK, lvl, rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
  endtask

  // Wait until every transaction is taken and every result is back
  task automatic drain();
    while (pending_items.size() != 0 || in_if.valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_debounce(logic [7:0] ticks);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_DEBOUNCE;
    pwdata  <= {24'($urandom), ticks};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    debounce_setting = ticks;
    settings_written++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    compare_field("debounce readback", 32'(ticks), 32'(prdata[7:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] colour_value();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return rnd_byte();
    endcase
  endfunction

  // Mostly level runs long enough to pass the debounce, some cut short or
  // with a glitch, mixed with status reads, clears and colour writes
  task automatic queue_random(int unsigned count);
    int unsigned made;
    int unsigned pick;
    int unsigned run_len;
    int unsigned glitch_at;
    int unsigned span;
    made = 0;
    span = (debounce_setting == 8'd0) ? 32'd1 : 32'(debounce_setting);
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        gen_level = ~gen_level;
        if ($urandom_range(0, 3) == 0) run_len = $urandom_range(1, span);
        else run_len = span + $urandom_range(0, 3);
        glitch_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, run_len - 1) : run_len;
        for (int unsigned i = 0; i < run_len; i++)
          queue_tick((i == glitch_at) ? ~gen_level : gen_level);
        made += run_len;
      end else begin
        if (pick < 75)
          queue_item(CMD_STATUS, rnd_bit(), rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
        else if (pick < 80)
          queue_item(CMD_CLEAR_COUNT, rnd_bit(), rnd_byte(), rnd_byte(), rnd_byte(),
                     rnd_byte());
        else if (pick < 90)
          queue_item(CMD_SET_COLOUR, rnd_bit(), colour_value(), colour_value(),
                     colour_value(), colour_value());
        else if (pick < 95)
          queue_item(CMD_COLOUR_OFF, rnd_bit(), rnd_byte(), rnd_byte(), rnd_byte(),
                     rnd_byte());
        else
          queue_item(3'($urandom_range(32'(CMD_UNUSED_FIRST), 32'(CMD_UNUSED_LAST))),
                     rnd_bit(), rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
        made++;
      end
    end
  endtask

  initial begin
    logic [7:0] rand_ticks;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_if.valid     = 1'b0;
    in_if.cmd       = CMD_TICK;
    in_if.raw_level = 1'b1;
    in_if.red_in    = '0;
    in_if.green_in  = '0;
    in_if.blue_in   = '0;
    in_if.white_in  = '0;
    out_if.ready    = 1'b0;

    debounce_setting = DEBOUNCE_RESET;
    stable_level     = 1'b1;
    mismatch_run     = '0;
    button_down      = 1'b0;
    press_edge       = 1'b0;
    release_edge     = 1'b0;
    press_count      = '0;
    {colour_r, colour_g, colour_b, colour_w} = '0;
    gen_level        = 1'b1;
    tx_idle_en       = 1'b1;
    rx_idle_en       = 1'b1;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting: short runs are not accepted
    queue_item(CMD_STATUS, 1'b0, 8'hff, 8'hff, 8'hff, 8'hff);
    queue_tick(1'b1);
    queue_tick(1'b0);
    queue_tick(1'b0);
    queue_tick(1'b1);

    program_debounce(8'd2);
    queue_tick(1'b0);
    queue_tick(1'b1);
    queue_tick(1'b0);
    queue_tick(1'b0);
    for (logic [3:0] c = {1'b0, CMD_UNUSED_FIRST}; c <= {1'b0, CMD_UNUSED_LAST}; c++)
      queue_item(c[2:0], rnd_bit(), rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
    queue_item(CMD_STATUS, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_item(CMD_STATUS, 1'b0, 8'hff, 8'hff, 8'hff, 8'hff);
    queue_item(CMD_SET_COLOUR, 1'b0, 8'hff, 8'hff, 8'hff, 8'hff);
    queue_item(CMD_SET_COLOUR, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_item(CMD_SET_COLOUR, rnd_bit(), rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
    queue_item(CMD_COLOUR_OFF, 1'b0, 8'hff, 8'hff, 8'hff, 8'hff);
    queue_tick(1'b1);
    queue_tick(1'b1);
    queue_item(CMD_CLEAR_COUNT, 1'b0, 8'hff, 8'hff, 8'hff, 8'hff);
    queue_item(CMD_STATUS, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);

    // Zero setting acts on the first differing tick
    program_debounce(8'd0);
    queue_tick(1'b0);
    queue_tick(1'b1);
    queue_item(CMD_STATUS, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b0;
    program_debounce(DEBOUNCE_RESET);
    queue_random(150);

    // Shortest debounce: drive the press counter into saturation
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    program_debounce(8'd1);
    for (int unsigned i = 0; i < 265; i++) begin
      queue_tick(1'b0);
      queue_tick(1'b1);
      if (i % 40 == 39)
        queue_item(CMD_STATUS, rnd_bit(), rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
    end
    queue_item(CMD_STATUS, rnd_bit(), rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
    queue_random(60);

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    program_debounce(8'd255);
    queue_random(240);

    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    program_debounce(8'd0);
    queue_random(80);

    // Sender keeps offering while the receiver holds off: let the block fill
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    program_debounce(8'd3);
    @(negedge clk_i);
    holdoff_requests++;
    queue_random(120);

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    rand_ticks = 8'($urandom_range(4, 40));
    program_debounce(rand_ticks);
    queue_random(80);

    drain();
    repeat (8) @(posedge clk_i);
    $display("Checked %0d results from %0d transactions over %0d debounce settings.",
             results_checked, items_accepted, settings_written);
    $display("Presses accepted: %0d, of which %0d arrived with the counter full.",
             presses_accepted, saturated_presses);
    if (error_count == 0) begin
      $display("debounced_button_status_register_test: done, clean");
    end else begin
      $display("debounced_button_status_register_test: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
design/dbs_pkg.sv
design/dbs_in_if.sv
design/dbs_out_if.sv
design/dbs_cfg.sv
design/dbs_core.sv
design/debounced_button_status_register.sv
tb/debounced_button_status_register_test.sv
